>>> src/csr_pkg.sv
// ----------------------------------------------------------------------------
// csr_pkg
// Shared types, widths and codes for the centre-out spiral reader.
// ----------------------------------------------------------------------------
package csr_pkg;

  // Fixed widths of the word fields
  localparam int HALF_W  = 3;   // half_size register
  localparam int COORD_W = 4;   // row / column / leg lengths (side <= 15)
  localparam int POS_W   = 8;   // spiral ordinal and row-major index
  localparam int VALUE_W = 32;  // element value on the ports

  // Defaults for the top-level parameters
  localparam int MAX_HALF_SIZE_DEF = 7;
  localparam int DATA_WIDTH_DEF    = 32;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Walk direction, in turn order
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr;    // store the accepted write word
    logic move;  // step the walker for an accepted next word
    logic read;  // read the store, latch position/last, advance leg state
    logic emit;  // result word is on the out_ ports
  } cmd_t;

endpackage

>>> src/csr_ctrl.sv
// ----------------------------------------------------------------------------
// csr_ctrl
// Sequencer: accepts words, then runs read and emit for a next command.
// ----------------------------------------------------------------------------
module csr_ctrl
  import csr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_command,
  output logic busy,
  output logic out_strobe,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_NEXT)) state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_EMIT;
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.wr     = accept && (in_command == CMD_WRITE);
  assign cmd.move   = accept && (in_command == CMD_NEXT);
  assign cmd.read   = (state_r == S_READ);
  assign cmd.emit   = (state_r == S_EMIT);
  assign out_strobe = cmd.emit;

  // An accepted next word yields its strobe in the emit state, after the read state
  a_next_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |=> ##1 out_strobe)
    else $error("next word did not produce a strobe");

  // Emit is only ever reached straight from the read state
  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> $past(state_r == S_READ))
    else $error("emit without preceding read");

  // Nothing is accepted while a result is being produced
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.read || cmd.emit) |-> !(cmd.wr || cmd.move))
    else $error("word accepted while busy");

endmodule

>>> src/csr_datapath.sv
// ----------------------------------------------------------------------------
// csr_datapath
// Matrix store, spiral walker registers and result registers.
// ----------------------------------------------------------------------------
module csr_datapath
  import csr_pkg::*;
#(
  parameter int MAX_HALF_SIZE = MAX_HALF_SIZE_DEF,
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  input  logic                      cfg_we,
  input  logic [HALF_W-1:0]         cfg_half_size,
  input  logic [POS_W-1:0]          in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic signed [VALUE_W-1:0] out_element,
  output logic [POS_W-1:0]          out_position,
  output logic                      out_last
);

  localparam int SIDE_MAX = 2 * MAX_HALF_SIZE + 1;
  localparam int DEPTH    = SIDE_MAX * SIDE_MAX;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Store: written in idle, read in the read state
  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Walker state
  logic [HALF_W-1:0]  half_r,    half_nxt;
  logic [COORD_W-1:0] row_r,     row_nxt;
  logic [COORD_W-1:0] col_r,     col_nxt;
  dir_t               dir_r,     dir_nxt;
  logic [COORD_W-1:0] leg_r,     leg_nxt;
  logic [COORD_W-1:0] steps_r,   steps_nxt;
  logic               second_r,  second_nxt;
  logic [POS_W-1:0]   emitted_r, emitted_nxt;

  logic [POS_W-1:0]   pos_r;
  logic               last_r;

  logic [COORD_W-1:0] side;
  logic [POS_W-1:0]   total;
  logic [POS_W-1:0]   rd_addr;
  logic               is_last;
  logic               wr_ok;
  logic [HALF_W-1:0]  half_sat;

  assign side    = {half_r, 1'b1};
  assign total   = POS_W'(side) * POS_W'(side);
  assign rd_addr = (POS_W'(row_r) * POS_W'(side)) + POS_W'(col_r);
  assign is_last = ({1'b0, emitted_r} + 9'd1) >= {1'b0, total};
  assign wr_ok   = (in_index < total) && (int'(in_index) < DEPTH);
  assign half_sat = (int'(cfg_half_size) > MAX_HALF_SIZE) ? HALF_W'(MAX_HALF_SIZE)
                                                          : cfg_half_size;

  always_comb begin
    half_nxt    = half_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    dir_nxt     = dir_r;
    leg_nxt     = leg_r;
    steps_nxt   = steps_r;
    second_nxt  = second_r;
    emitted_nxt = emitted_r;
    if (cfg_we) begin
      // new size: restart at the new centre, store kept
      half_nxt    = half_sat;
      row_nxt     = COORD_W'(half_sat);
      col_nxt     = COORD_W'(half_sat);
      dir_nxt     = DIR_LEFT;
      leg_nxt     = COORD_W'(1);
      steps_nxt   = '0;
      second_nxt  = 1'b0;
      emitted_nxt = '0;
    end else if (cmd.move) begin
      if (emitted_r != '0) begin
        case (dir_r)
          DIR_LEFT:  col_nxt = col_r - COORD_W'(1);
          DIR_DOWN:  row_nxt = row_r + COORD_W'(1);
          DIR_RIGHT: col_nxt = col_r + COORD_W'(1);
          default:   row_nxt = row_r - COORD_W'(1);
        endcase
        steps_nxt = steps_r - COORD_W'(1);
      end else begin
        steps_nxt = COORD_W'(1);
      end
    end else if (cmd.read) begin
      if (is_last) begin
        row_nxt     = COORD_W'(half_r);
        col_nxt     = COORD_W'(half_r);
        dir_nxt     = DIR_LEFT;
        leg_nxt     = COORD_W'(1);
        steps_nxt   = '0;
        second_nxt  = 1'b0;
        emitted_nxt = '0;
      end else begin
        emitted_nxt = emitted_r + POS_W'(1);
        // leg finished: turn, lengthen every second leg
        if ((emitted_r != '0) && (steps_r == '0)) begin
          dir_nxt = dir_t'(dir_r + 2'd1);
          if (!second_r) begin
            second_nxt = 1'b1;
            steps_nxt  = leg_r;
          end else begin
            second_nxt = 1'b0;
            leg_nxt    = leg_r + COORD_W'(1);
            steps_nxt  = leg_r + COORD_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= '0;
      row_r     <= '0;
      col_r     <= '0;
      dir_r     <= DIR_LEFT;
      leg_r     <= COORD_W'(1);
      steps_r   <= '0;
      second_r  <= 1'b0;
      emitted_r <= '0;
    end else begin
      half_r    <= half_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      dir_r     <= dir_nxt;
      leg_r     <= leg_nxt;
      steps_r   <= steps_nxt;
      second_r  <= second_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // Store and registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem_r[ADDR_W'(in_index)] <= DATA_WIDTH'($unsigned(in_value));
    end
    if (cmd.read) begin
      rdata_r <= mem_r[ADDR_W'(rd_addr)];
      pos_r   <= emitted_r;
      last_r  <= is_last;
    end
  end

  assign out_element  = signed'(VALUE_W'(rdata_r));
  assign out_position = pos_r;
  assign out_last     = last_r;

  // Walker never leaves the matrix
  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < side) && (col_r < side))
    else $error("walker outside matrix");

  // Remaining steps never exceed the current leg
  a_steps_le_leg: assert property (@(posedge clk) disable iff (!rst_n)
    (emitted_r != '0) |-> (steps_r <= leg_r))
    else $error("steps_left beyond leg length");

  // Last flag only on the final ordinal
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && last_r) |-> (({1'b0, pos_r} + 9'd1) == {1'b0, total}))
    else $error("last flag on wrong position");

endmodule

>>> src/center_out_spiral_reader_unit.sv
// ----------------------------------------------------------------------------
// center_out_spiral_reader_unit
// Square matrix store read back in centre-out spiral order.
// ----------------------------------------------------------------------------
// Using the block: the matrix side is 2*half_size+1 (half_size written on
// cfg_half_size with cfg_we, saturated to MAX_HALF_SIZE; a write restarts the
// walk at the new centre and keeps the store). A word is taken when start is
// high and busy is low. A write word (in_command = 0) stores in_value at the
// row-major in_index; indices of side*side or more are dropped. A next word
// (in_command = 1) returns one element: out_strobe is high for exactly one
// cycle, in the emit state, reached through the read state from the accepting
// cycle, with out_element, out_position (the spiral ordinal) and out_last.
// There is no back-pressure: the result must be taken in that cycle. A next
// word runs through accept and walker step, registered store read and the
// result cycle, and busy stays high through the result cycle, so a new word
// is taken only after the result cycle of the one before. Order is centre,
// then legs left, down, right, up of lengths 1,1,2,2,...; after the word
// flagged out_last the walk starts again at the centre. Elements never
// written read as undefined data. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module center_out_spiral_reader_unit
  import csr_pkg::*;
#(
  parameter int MAX_HALF_SIZE = MAX_HALF_SIZE_DEF,
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [HALF_W-1:0]         cfg_half_size,
  // command words
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic [POS_W-1:0]          in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  // result words
  output logic                      out_strobe,
  output logic signed [VALUE_W-1:0] out_element,
  output logic [POS_W-1:0]          out_position,
  output logic                      out_last
);

  cmd_t cmd;

  // sequencer: idle -> read -> emit for next words, writes stay idle
  csr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // store, walker and result registers
  csr_datapath #(
    .MAX_HALF_SIZE (MAX_HALF_SIZE),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_half_size (cfg_half_size),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_element   (out_element),
    .out_position  (out_position),
    .out_last      (out_last)
  );

endmodule
